FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define TSP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/tsp_pkg.sv
// Types and constants for the transport stream payload extractor.
package tsp_pkg;

  localparam int unsigned POS_W         = 8;
  localparam int unsigned PID_W         = 13;
  localparam int unsigned BEGIN_W       = 9;
  localparam int unsigned TS_PKT_LEN    = 188;
  localparam int unsigned FIFO_DEPTH    = 4;

  localparam logic [7:0] TS_SYNC        = 8'h47;
  localparam logic [1:0] AC_NO_PAYLOAD  = 2'd2;
  localparam logic [1:0] AC_ADAPT_PAYLD = 2'd3;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_SYNC   = 8'd0;
  localparam logic [POS_W-1:0] POS_PID_HI = 8'd1;
  localparam logic [POS_W-1:0] POS_PID_LO = 8'd2;
  localparam logic [POS_W-1:0] POS_FLAGS  = 8'd3;
  localparam logic [POS_W-1:0] POS_AF_LEN = 8'd4;
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(TS_PKT_LEN - 1);

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_last;
  } out_item_t;

  // Queue status seen by the output stage
  typedef struct packed {
    logic      avail;
    out_item_t head;
  } q_stat_t;

endpackage

FILE: sv/tsp_front.sv
// Front end: tracks packet position, parses the header, selects payload bytes.
module tsp_front import tsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [PID_W-1:0] cfg_wdata,
  input  logic             accept,
  input  in_item_t         in_item,
  output logic             emit,
  output out_item_t        emit_item
);

  logic [PID_W-1:0]   wanted_pid;
  logic [POS_W-1:0]   byte_position;
  logic               header_ok;
  logic [4:0]         pid_high_bits;
  logic [1:0]         adaptation_mode;
  logic [BEGIN_W-1:0] payload_begin;

  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   byte_position_next;
  logic               header_ok_next;
  logic [4:0]         pid_high_bits_next;
  logic [1:0]         adaptation_mode_next;
  logic [BEGIN_W-1:0] payload_begin_next;
  logic [7:0]         b;

  assign b       = in_item.stream_byte;
  assign pos_cur = in_item.chunk_start ? POS_SYNC : byte_position;

  always_comb begin
    header_ok_next       = header_ok;
    pid_high_bits_next   = pid_high_bits;
    adaptation_mode_next = adaptation_mode;
    payload_begin_next   = payload_begin;
    case (pos_cur)
      POS_SYNC: begin
        header_ok_next = (b == TS_SYNC);
      end
      POS_PID_HI: begin
        if (b[7]) begin
          header_ok_next = 1'b0;
        end
        pid_high_bits_next = b[4:0];
      end
      POS_PID_LO: begin
        if ({pid_high_bits, b} != wanted_pid) begin
          header_ok_next = 1'b0;
        end
      end
      POS_FLAGS: begin
        adaptation_mode_next = b[5:4];
        if (b[5:4] == AC_NO_PAYLOAD) begin
          header_ok_next = 1'b0;
        end
        payload_begin_next = (b[5:4] == AC_ADAPT_PAYLD) ? BEGIN_W'(5) : BEGIN_W'(4);
      end
      POS_AF_LEN: begin
        if (adaptation_mode == AC_ADAPT_PAYLD) begin
          payload_begin_next = BEGIN_W'(5) + {1'b0, b};
          if (payload_begin_next >= BEGIN_W'(TS_PKT_LEN)) begin
            header_ok_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign byte_position_next = (pos_cur >= POS_LAST) ? POS_SYNC : pos_cur + 8'd1;

  assign emit = accept && header_ok_next && (pos_cur >= POS_AF_LEN)
             && ({1'b0, pos_cur} >= payload_begin_next);
  assign emit_item.payload_byte = b;
  assign emit_item.packet_last  = (pos_cur == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_pid      <= '0;
      byte_position   <= '0;
      header_ok       <= 1'b0;
      pid_high_bits   <= '0;
      adaptation_mode <= '0;
      payload_begin   <= BEGIN_W'(4);
    end else begin
      if (cfg_we) begin
        wanted_pid <= cfg_wdata;
      end
      if (accept) begin
        byte_position   <= byte_position_next;
        header_ok       <= header_ok_next;
        pid_high_bits   <= pid_high_bits_next;
        adaptation_mode <= adaptation_mode_next;
        payload_begin   <= payload_begin_next;
      end
    end
  end

endmodule

FILE: sv/tsp_fifo.sv
// Short queue between the front end and the output stage.
module tsp_fifo import tsp_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  out_item_t wr_item,
  input  logic      rd_en,
  output q_stat_t   stat,
  output logic      q_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  out_item_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign q_full     = (count == CW'(DEPTH));
  assign stat.avail = (count != '0);
  assign stat.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/tsp_back.sv
// Output stage: holds the beat on the result ports until it is popped.
module tsp_back import tsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_stat_t   stat,
  output logic      q_rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic valid;

  assign empty = !valid;
  // Refill when the register is free or being drained this cycle.
  assign q_rd  = stat.avail && (!valid || pop);

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_item <= stat.head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_rd) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

endmodule

FILE: sv/ts_pid_payload_extractor.sv
// Top level of the transport stream PID filter and payload extractor.
//
//   channel   direction  handshake        beat
//   input     in         push / full      in_item  {stream_byte, chunk_start}
//   result    out        pop / empty      out_item {payload_byte, packet_last}
//   config    in         cfg_we           cfg_wdata (wanted PID, 13 bits)
//
// One input beat is taken per cycle while the queue is not full; a payload
// byte passes through the queue and the output register before it shows on
// the result ports. The front end's position counter steps once per beat.
// Reset (rst, synchronous) clears position, header state and queues;
// the wanted PID returns to 0. full rises only when the queue between the
// front end and the output stage is full, so a stalled reader holds input.
module ts_pid_payload_extractor import tsp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [PID_W-1:0] cfg_wdata
);

  logic      accept;
  logic      emit;
  out_item_t emit_item;
  logic      q_rd;
  q_stat_t   q_stat;

  // Take a beat whenever the queue has room for whatever it may produce.
  assign accept = push && !full;

  tsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_item   (in_item),
    .emit      (emit),
    .emit_item (emit_item)
  );

  // Decouple parsing from the reader.
  tsp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (emit),
    .wr_item (emit_item),
    .rd_en   (q_rd),
    .stat    (q_stat),
    .q_full  (full)
  );

  tsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stat     (q_stat),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

FILE: sv/tsp_checker.sv
// Port-level checker for the payload extractor, with its bind.
`include "assert_macros.svh"

module tsp_checker import tsp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  logic take;

  // A beat accepted on the input side this cycle.
  assign take = push && !full;

  `TSP_ASSERT_ALWAYS(a_rst_empty, clk, rst, empty)
  `TSP_ASSERT_ALWAYS(a_rst_not_full, clk, rst, !full)
  `TSP_ASSERT_NEXT(a_no_spurious, clk, rst, empty && !take && !$past(take), empty)
  `TSP_ASSERT_NEXT(a_hold_beat, clk, rst, !empty && !pop, !empty && $stable(out_item))

endmodule

bind ts_pid_payload_extractor tsp_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
